[src/ipru_pkg.sv]
// ----------------------------------------------------------------------------
// ipru_pkg: shared types and constants for the indexed pixel row unpacker
// Channel payloads, queue entry layout, depth codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ipru_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_ROW_PIXELS_DEF  = 4096;
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int QUEUE_DEPTH_DEF     = 4;

	// Configuration port
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BPP       = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH = 1'd1;

	// Register reset values
	localparam logic [3:0]  BPP_RESET       = 4'd8;
	localparam logic [12:0] ROW_WIDTH_RESET = 13'd1;

	// Pixel unpack masks
	localparam logic [7:0] HI_NIBBLE = 8'hF0;
	localparam logic [7:0] LO_NIBBLE = 8'h0F;
	localparam logic [7:0] BIT_MASK  = 8'h01;

	// Row size granule in bits
	localparam int ROW_ALIGN_BITS = 32;

	// Supported pixel depths
	typedef enum logic [1:0] {
		BPP_1 = 2'd0,
		BPP_4 = 2'd1,
		BPP_8 = 2'd2
	} bpp_code_t;

	// Input transaction
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  entry_index;
		logic [23:0] entry_color;
	} item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0]  pixel_index;
		logic [23:0] pixel_color;
		logic        palette_miss;
		logic        row_end;
		logic        run_last;
	} pixel_t;

	// Classified command passed from front to back
	typedef struct packed {
		logic        is_load;
		logic [7:0]  value;     // data byte or palette slot
		logic [23:0] color;
		bpp_code_t   bpp;
		logic [3:0]  count;     // pixels to emit, 1..8
		logic        row_end;   // last emitted pixel closes the row
	} cmd_t;

	// Queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[src/ipru_ram.sv]
// ----------------------------------------------------------------------------
// ipru_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/ipru_front.sv]
// ----------------------------------------------------------------------------
// ipru_front: input acceptance, configuration and row bookkeeping
// Tracks the byte position and pixel column within a row, works out how many
// pixels each bitmap byte yields and queues palette loads and pixel runs.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_front import ipru_pkg::*; #(
	parameter int MAX_ROW_PIXELS  = MAX_ROW_PIXELS_DEF,
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire item_t                  item,
	// queue
	input  wire q_status_t              q_status,
	output logic                        push,
	output cmd_t                        cmd
);

	localparam int W_W    = $clog2(MAX_ROW_PIXELS + 1);
	localparam int WIDE_W = (W_W > CFG_DATA_W) ? W_W : CFG_DATA_W;
	localparam int BITS_W = $clog2(MAX_ROW_PIXELS * 15 + ROW_ALIGN_BITS);
	localparam int RB_MAX = ((MAX_ROW_PIXELS * 15 + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS) * 4;
	localparam int BIR_W  = $clog2(RB_MAX + 1);
	localparam int PC_W   = $clog2(MAX_ROW_PIXELS * 8 + 64);
	localparam int SH_W   = $clog2(ROW_ALIGN_BITS);

	logic [3:0]        bpp_q;
	logic [12:0]       row_width_q;
	logic [BIR_W-1:0]  byte_in_row_q;
	logic [PC_W-1:0]   pixel_column_q;

	logic [W_W-1:0]    width_eff;
	logic [BIR_W-1:0]  row_bytes;
	logic              wrap;
	logic [BIR_W-1:0]  bir_eff;
	logic [PC_W-1:0]   pc_eff;
	logic [3:0]        ppb;
	bpp_code_t         bpp_code;
	logic [3:0]        n_pix;
	logic              end_row;
	logic [BIR_W-1:0]  bir_nxt;
	logic [PC_W-1:0]   pc_nxt;
	logic              accept;

	assign cfg_ready  = 1'b1;
	assign item_ready = !q_status.full;
	assign accept     = item_valid && item_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q       <= BPP_RESET;
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BPP:       bpp_q       <= cfg_data[3:0];
				CFG_ROW_WIDTH: row_width_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Effective width and row size in bytes (whole 32-bit words, at least one)
	always_comb begin
		logic [WIDE_W-1:0] rw_ext;
		logic [WIDE_W-1:0] max_ext;
		logic [BITS_W-1:0] bits;
		logic [BITS_W-1:0] words;
		rw_ext    = WIDE_W'(row_width_q);
		max_ext   = WIDE_W'(MAX_ROW_PIXELS);
		width_eff = W_W'((rw_ext > max_ext) ? max_ext : rw_ext);
		bits      = BITS_W'(width_eff) * BITS_W'(bpp_q);
		words     = (bits + BITS_W'(ROW_ALIGN_BITS - 1)) >> SH_W;
		if (words == '0) begin
			words = BITS_W'(1);
		end
		row_bytes = BIR_W'({words, 2'b00});
	end

	// Pixel depth decode
	always_comb begin
		unique case (bpp_q)
			4'd1: begin
				ppb      = 4'd8;
				bpp_code = BPP_1;
			end
			4'd4: begin
				ppb      = 4'd2;
				bpp_code = BPP_4;
			end
			4'd8: begin
				ppb      = 4'd1;
				bpp_code = BPP_8;
			end
			default: begin
				ppb      = 4'd0;
				bpp_code = BPP_8;
			end
		endcase
	end

	// Row position, pixel count of this byte and next counters
	always_comb begin
		logic [PC_W-1:0] w_ext;
		logic [PC_W-1:0] remain;
		logic [PC_W-1:0] ppb_ext;
		wrap    = (byte_in_row_q >= row_bytes);
		bir_eff = wrap ? '0 : byte_in_row_q;
		pc_eff  = wrap ? '0 : pixel_column_q;
		w_ext   = PC_W'(width_eff);
		ppb_ext = PC_W'(ppb);
		remain  = (pc_eff < w_ext) ? (w_ext - pc_eff) : '0;
		n_pix   = (remain >= ppb_ext) ? ppb : remain[3:0];
		end_row = ((pc_eff + ppb_ext) >= w_ext);
		bir_nxt = bir_eff + BIR_W'(1);
		pc_nxt  = pc_eff + ppb_ext;
		if (bir_nxt >= row_bytes) begin
			bir_nxt = '0;
			pc_nxt  = '0;
		end
	end

	// Row counters advance on each accepted bitmap byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q  <= '0;
			pixel_column_q <= '0;
		end else if (accept && item.kind) begin
			byte_in_row_q  <= bir_nxt;
			pixel_column_q <= pc_nxt;
		end
	end

	// Classify: loads into the palette range and bytes that yield pixels
	always_comb begin
		cmd.is_load = !item.kind;
		cmd.value   = item.kind ? item.data_byte : item.entry_index;
		cmd.color   = item.entry_color;
		cmd.bpp     = bpp_code;
		cmd.count   = n_pix;
		cmd.row_end = end_row;
		if (item.kind) begin
			push = accept && (n_pix != 4'd0);
		end else begin
			push = accept && ({1'b0, item.entry_index} < 9'(PALETTE_ENTRIES));
		end
	end

endmodule

`default_nettype wire

[src/ipru_queue.sv]
// ----------------------------------------------------------------------------
// ipru_queue: short command queue between front and back
// Register-based FIFO; the head entry is visible for the back to work on.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_queue import ipru_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output cmd_t       head,
	output logic       head_valid,
	output q_status_t  status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head_valid   = !status.empty;
	assign head         = entry_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[src/ipru_back.sv]
// ----------------------------------------------------------------------------
// ipru_back: palette update and pixel emission
// Applies palette loads in order and walks each queued byte one pixel per
// cycle unless stalled, looking each index up in palette RAM and loaded flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_back import ipru_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic head_valid,
	output logic      pop,
	output logic      pixel_valid,
	input  wire logic pixel_ready,
	output pixel_t    pixel
);

	localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

	logic [PALETTE_ENTRIES-1:0] loaded_q;
	logic [2:0]                 k_q;
	logic                       valid_s2;
	logic [7:0]                 idx_s2;
	logic                       hit_s2;
	logic                       row_end_s2;
	logic                       last_s2;
	logic [23:0]                ram_rd_data;

	logic        s2_free;
	logic        do_load;
	logic        do_pix;
	logic        last_pix;
	logic [7:0]  idx;
	logic        hit;

	assign s2_free  = !valid_s2 || pixel_ready;
	assign do_load  = head_valid && head.is_load;
	assign do_pix   = head_valid && !head.is_load && s2_free;
	assign last_pix = (({1'b0, k_q} + 4'd1) == head.count);
	assign pop      = do_load || (do_pix && last_pix);

	// Pixel index extraction, most significant bits first
	always_comb begin
		unique case (head.bpp)
			BPP_1:   idx = (head.value >> (3'd7 - k_q)) & BIT_MASK;
			BPP_4:   idx = (k_q == 3'd0) ? ((head.value & HI_NIBBLE) >> 4)
			                             : (head.value & LO_NIBBLE);
			BPP_8:   idx = head.value;
			default: idx = head.value;
		endcase
		hit = ({1'b0, idx} < 9'(PALETTE_ENTRIES)) && loaded_q[idx[ADDR_W-1:0]];
	end

	// Palette colors
	ipru_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (do_load),
		.wr_addr (head.value[ADDR_W-1:0]),
		.wr_data (head.color),
		.rd_en   (do_pix),
		.rd_addr (idx[ADDR_W-1:0]),
		.rd_data (ram_rd_data)
	);

	// Loaded flags, pixel counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			k_q      <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (do_load) begin
				loaded_q[head.value[ADDR_W-1:0]] <= 1'b1;
			end
			if (do_pix) begin
				k_q <= last_pix ? 3'd0 : k_q + 3'd1;
			end
			if (do_pix) begin
				valid_s2 <= 1'b1;
			end else if (pixel_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (do_pix) begin
			idx_s2     <= idx;
			hit_s2     <= hit;
			row_end_s2 <= last_pix && head.row_end;
			last_s2    <= last_pix;
		end
	end

	assign pixel_valid        = valid_s2;
	assign pixel.pixel_index  = idx_s2;
	assign pixel.pixel_color  = hit_s2 ? ram_rd_data : 24'd0;
	assign pixel.palette_miss = !hit_s2;
	assign pixel.row_end      = row_end_s2;
	assign pixel.run_last     = last_s2;

endmodule

`default_nettype wire

[src/indexed_pixel_row_unpacker_top.sv]
// ----------------------------------------------------------------------------
// indexed_pixel_row_unpacker_top: palette bitmap row unpacker, 1/4/8 bpp
// Items are taken while the queue is not full; a bitmap byte holds the back
// unit until each of its pixels (up to 8 at 1 bpp) is issued, a palette load
// until applied. Pixels pass the command queue and the output register.
// Reset: 8 bpp, row width 1, all palette slots unloaded, row counters zero.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_pixel_row_unpacker_top import ipru_pkg::*; #(
	parameter int MAX_ROW_PIXELS  = MAX_ROW_PIXELS_DEF,
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire item_t                  item,
	output logic                        pixel_valid,
	input  wire logic                   pixel_ready,
	output pixel_t                      pixel
);

	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;
	logic      head_valid;

	// Front: accept and classify
	ipru_front #(
		.MAX_ROW_PIXELS  (MAX_ROW_PIXELS),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.cmd        (push_cmd)
	);

	// Command queue
	ipru_queue #(
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.status     (q_status)
	);

	// Back: palette update and pixel output
	ipru_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

endmodule

`default_nettype wire
